// ===== hdl/tae_pkg.sv =====
package tae_pkg;

   // Register file geometry
   localparam int RegCount    = 15;
   localparam int RegIdxWidth = 4;
   localparam int DataWidth   = 32;

   localparam logic [RegIdxWidth-1:0] SpIndex = 4'd13;
   localparam logic [RegIdxWidth-1:0] PcIndex = 4'd15;

   localparam logic [DataWidth-1:0] WordAlignMask = 32'hFFFF_FFFC;

   // NZCV bit positions
   localparam int FlagN = 3;
   localparam int FlagZ = 2;
   localparam int FlagC = 1;
   localparam int FlagV = 0;

   typedef enum logic [1:0] {
      KIND_EXEC       = 2'd0,
      KIND_LOAD_REG   = 2'd1,
      KIND_LOAD_FLAGS = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      OP_ADC  = 4'd0,
      OP_ADD1 = 4'd1,
      OP_ADD2 = 4'd2,
      OP_ADD3 = 4'd3,
      OP_ADD4 = 4'd4,
      OP_ADD5 = 4'd5,
      OP_ADD6 = 4'd6,
      OP_ADD7 = 4'd7,
      OP_SBC  = 4'd8,
      OP_SUB1 = 4'd9,
      OP_SUB2 = 4'd10,
      OP_SUB3 = 4'd11,
      OP_SUB4 = 4'd12,
      OP_MUL  = 4'd13
   } op_type;

   typedef struct packed {
      kind_type                kind;
      op_type                  op;
      logic [15:0]             code;
      logic [DataWidth-1:0]    pc_value;
      logic [RegIdxWidth-1:0]  load_index;
      logic [DataWidth-1:0]    load_value;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0]    dest_value;
      logic [RegIdxWidth-1:0]  dest_index;
      logic                    dest_written;
      logic [3:0]              flags_nzcv;
      logic                    branch_taken;
   } rsp_type;

   typedef struct packed {
      logic                    en;
      logic [RegIdxWidth-1:0]  index;
      logic [DataWidth-1:0]    value;
   } rf_write_type;

   // First source register of an instruction
   function automatic logic [RegIdxWidth-1:0] src_a_index(input op_type op,
                                                          input logic [15:0] code);
      logic [RegIdxWidth-1:0] idx;
      idx = '0;
      case (op)
         OP_ADC, OP_SBC:                    idx = {1'b0, code[2:0]};
         OP_ADD1, OP_ADD3, OP_SUB1,
         OP_SUB3, OP_MUL:                   idx = {1'b0, code[5:3]};
         OP_ADD2, OP_SUB2:                  idx = {1'b0, code[10:8]};
         OP_ADD4:                           idx = {code[7], code[2:0]};
         OP_ADD6, OP_ADD7, OP_SUB4:         idx = SpIndex;
         default:                           idx = '0;
      endcase
      return idx;
   endfunction

   // Second source register of an instruction
   function automatic logic [RegIdxWidth-1:0] src_b_index(input op_type op,
                                                          input logic [15:0] code);
      logic [RegIdxWidth-1:0] idx;
      idx = '0;
      case (op)
         OP_ADC, OP_SBC:    idx = {1'b0, code[5:3]};
         OP_ADD3, OP_SUB3:  idx = {1'b0, code[8:6]};
         OP_ADD4:           idx = {code[6], code[5:3]};
         OP_MUL:            idx = {1'b0, code[2:0]};
         default:           idx = '0;
      endcase
      return idx;
   endfunction

endpackage

// ===== hdl/tae_regfile.sv =====
module tae_regfile (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [tae_pkg::RegIdxWidth-1:0]        rd_addr_a,
   input  logic [tae_pkg::RegIdxWidth-1:0]        rd_addr_b,
   input  logic [tae_pkg::DataWidth-1:0]          pc_value,
   input  tae_pkg::rf_write_type                  wr,
   output logic [tae_pkg::DataWidth-1:0]          rd_data_a,
   output logic [tae_pkg::DataWidth-1:0]          rd_data_b
);

   logic [tae_pkg::DataWidth-1:0] mem_ff [tae_pkg::RegCount];
   logic [tae_pkg::DataWidth-1:0] rd_a_ff;
   logic [tae_pkg::DataWidth-1:0] rd_b_ff;
   logic [tae_pkg::DataWidth-1:0] rd_a_in;
   logic [tae_pkg::DataWidth-1:0] rd_b_in;

   // Pick PC, the value being written this cycle, or the stored entry
   function automatic logic [tae_pkg::DataWidth-1:0] read_port(
      input logic [tae_pkg::RegIdxWidth-1:0] addr);
      logic [tae_pkg::DataWidth-1:0] data;
      if (addr == tae_pkg::PcIndex) begin
         data = pc_value;
      end else if (wr.en && (wr.index == addr)) begin
         data = wr.value;
      end else begin
         data = mem_ff[addr];
      end
      return data;
   endfunction

   always_comb begin
      rd_a_in = read_port(rd_addr_a);
      rd_b_in = read_port(rd_addr_b);
   end

   // Write port; clear all entries on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tae_pkg::RegCount; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr.en) begin
         mem_ff[wr.index] <= wr.value;
      end
   end

   // Capture operands when a transaction enters
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/tae_alu.sv =====
module tae_alu (
   input  tae_pkg::req_type                   item,
   input  logic [tae_pkg::DataWidth-1:0]      opnd_a,
   input  logic [tae_pkg::DataWidth-1:0]      opnd_b,
   input  logic [3:0]                         flags,
   output tae_pkg::rsp_type                   rsp,
   output tae_pkg::rf_write_type              rf_wr,
   output logic [3:0]                         flags_next
);

   logic [tae_pkg::DataWidth-1:0]   add_a;
   logic [tae_pkg::DataWidth-1:0]   add_b;
   logic                            carry_in;
   logic                            sets_nzcv;
   logic                            is_mul;
   logic                            op_valid;
   logic [tae_pkg::RegIdxWidth-1:0] dst;
   logic [tae_pkg::DataWidth:0]     sum;
   logic [tae_pkg::DataWidth-1:0]   product;
   logic [tae_pkg::DataWidth-1:0]   exec_value;
   logic [3:0]                      sum_nzcv;
   logic [7:0]                      imm8;
   logic [6:0]                      imm7;

   assign imm8 = item.code[7:0];
   assign imm7 = item.code[6:0];

   // Select adder operands and destination per opcode
   always_comb begin
      add_a     = opnd_a;
      add_b     = '0;
      carry_in  = 1'b0;
      sets_nzcv = 1'b0;
      is_mul    = 1'b0;
      op_valid  = 1'b1;
      dst       = '0;
      case (item.op)
         tae_pkg::OP_ADC: begin
            add_b     = opnd_b;
            carry_in  = flags[tae_pkg::FlagC];
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_ADD1: begin
            add_b     = {29'b0, item.code[8:6]};
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_ADD2: begin
            add_b     = {24'b0, imm8};
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[10:8]};
         end
         tae_pkg::OP_ADD3: begin
            add_b     = opnd_b;
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_ADD4: begin
            add_b = opnd_b;
            dst   = {item.code[7], item.code[2:0]};
         end
         tae_pkg::OP_ADD5: begin
            add_a = item.pc_value & tae_pkg::WordAlignMask;
            add_b = {22'b0, imm8, 2'b00};
            dst   = {1'b0, item.code[10:8]};
         end
         tae_pkg::OP_ADD6: begin
            add_b = {22'b0, imm8, 2'b00};
            dst   = {1'b0, item.code[10:8]};
         end
         tae_pkg::OP_ADD7: begin
            add_b = {23'b0, imm7, 2'b00};
            dst   = tae_pkg::SpIndex;
         end
         tae_pkg::OP_SBC: begin
            add_b     = ~opnd_b;
            carry_in  = flags[tae_pkg::FlagC];
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_SUB1: begin
            add_b     = ~{29'b0, item.code[8:6]};
            carry_in  = 1'b1;
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_SUB2: begin
            add_b     = ~{24'b0, imm8};
            carry_in  = 1'b1;
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[10:8]};
         end
         tae_pkg::OP_SUB3: begin
            add_b     = ~opnd_b;
            carry_in  = 1'b1;
            sets_nzcv = 1'b1;
            dst       = {1'b0, item.code[2:0]};
         end
         tae_pkg::OP_SUB4: begin
            add_b    = ~{23'b0, imm7, 2'b00};
            carry_in = 1'b1;
            dst      = tae_pkg::SpIndex;
         end
         tae_pkg::OP_MUL: begin
            is_mul = 1'b1;
            dst    = {1'b0, item.code[2:0]};
         end
         default: begin
            op_valid = 1'b0;
         end
      endcase
   end

   // Shared adder and multiplier
   always_comb begin
      sum        = {1'b0, add_a} + {1'b0, add_b} + {{tae_pkg::DataWidth{1'b0}}, carry_in};
      product    = opnd_a * opnd_b;
      exec_value = is_mul ? product : sum[tae_pkg::DataWidth-1:0];
      sum_nzcv[tae_pkg::FlagN] = sum[tae_pkg::DataWidth-1];
      sum_nzcv[tae_pkg::FlagZ] = (sum[tae_pkg::DataWidth-1:0] == '0);
      sum_nzcv[tae_pkg::FlagC] = sum[tae_pkg::DataWidth];
      sum_nzcv[tae_pkg::FlagV] = ~(add_a[tae_pkg::DataWidth-1] ^ add_b[tae_pkg::DataWidth-1])
                               & (add_a[tae_pkg::DataWidth-1] ^ sum[tae_pkg::DataWidth-1]);
   end

   // Form the transaction result, next flags and register write
   always_comb begin
      rsp        = '0;
      flags_next = flags;
      case (item.kind)
         tae_pkg::KIND_EXEC: begin
            if (op_valid) begin
               rsp.dest_written = 1'b1;
               rsp.dest_index   = dst;
               rsp.dest_value   = exec_value;
               rsp.branch_taken = (item.op == tae_pkg::OP_ADD4) && (dst == tae_pkg::PcIndex);
               if (sets_nzcv) begin
                  flags_next = sum_nzcv;
               end else if (is_mul) begin
                  flags_next[tae_pkg::FlagN] = product[tae_pkg::DataWidth-1];
                  flags_next[tae_pkg::FlagZ] = (product == '0);
               end
            end
         end
         tae_pkg::KIND_LOAD_REG: begin
            if (item.load_index != tae_pkg::PcIndex) begin
               rsp.dest_written = 1'b1;
               rsp.dest_index   = item.load_index;
               rsp.dest_value   = item.load_value;
            end
         end
         tae_pkg::KIND_LOAD_FLAGS: begin
            flags_next = item.load_value[3:0];
         end
         default: begin
         end
      endcase
      rsp.flags_nzcv = flags_next;
      rf_wr.en       = rsp.dest_written && (rsp.dest_index != tae_pkg::PcIndex);
      rf_wr.index    = rsp.dest_index;
      rf_wr.value    = rsp.dest_value;
   end

endmodule

// ===== hdl/thumb_arith_execute_top.sv =====
// Pipeline: an accepted request passes through operand fetch and then execute to its response.
// Throughput: one transaction per cycle while the response is not stalled; the register file is read when a transaction
// enters and the executing transaction's write is forwarded into that read.
// Reset: synchronous, active high; clears r0..r14, the NZCV flags and both valid stages.
module thumb_arith_execute_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tae_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tae_pkg::rsp_type    rsp_data
);

   logic                           item_valid_ff;
   logic                           item_valid_in;
   tae_pkg::req_type               item_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   tae_pkg::rsp_type               rsp_data_ff;
   logic [3:0]                     flags_ff;
   logic [3:0]                     flags_in;
   logic                           advance;
   logic                           req_accept;
   logic [tae_pkg::DataWidth-1:0]  opnd_a;
   logic [tae_pkg::DataWidth-1:0]  opnd_b;
   tae_pkg::rsp_type               alu_rsp;
   tae_pkg::rf_write_type          alu_wr;
   tae_pkg::rf_write_type          rf_wr;

   // Handshake: move the executing transaction when the result slot frees up
   always_comb begin
      advance    = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall  = item_valid_ff && !advance;
      req_accept = req_valid && !req_stall;
      item_valid_in = req_accept || (item_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
      rf_wr.en    = alu_wr.en && advance;
      rf_wr.index = alu_wr.index;
      rf_wr.value = alu_wr.value;
   end

   tae_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_a (tae_pkg::src_a_index(req_data.op, req_data.code)),
      .rd_addr_b (tae_pkg::src_b_index(req_data.op, req_data.code)),
      .pc_value  (req_data.pc_value),
      .wr        (rf_wr),
      .rd_data_a (opnd_a),
      .rd_data_b (opnd_b)
   );

   tae_alu u_alu (
      .item       (item_ff),
      .opnd_a     (opnd_a),
      .opnd_b     (opnd_b),
      .flags      (flags_ff),
      .rsp        (alu_rsp),
      .rf_wr      (alu_wr),
      .flags_next (flags_in)
   );

   // Valid bits and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A register write never targets PC
   assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (rf_wr.index != tae_pkg::PcIndex))
      else $error("register write to PC index");

   // A branch is always a written PC destination
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.branch_taken) |->
         (rsp_data.dest_written && (rsp_data.dest_index == tae_pkg::PcIndex)))
      else $error("branch without PC destination");

   // Input stall only while the execute stage holds a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff)
      else $error("stall with empty execute stage");

   // A held transaction is not dropped
   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("execute stage transaction lost");

endmodule
